[src/assert_macros.svh]
// Assertion helpers for the RTL, included by sssf_back. Bodies vanish when SYNTH is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, ck, rn, cond) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (cond)) \
        else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, ck, rn, cond)
`define ASSERT_IMPLIES(lbl, ck, rn, ante, cons)
`define ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

[src/sssf_pkg.sv]
`default_nettype none
package sssf_pkg;

    localparam int DIGIT_COUNT = 4;
    localparam int GLYPH_W     = 5;
    localparam int SCAN_W      = 2;
    localparam int VALUE_W     = 16;
    localparam int MODE_W      = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 2;
    localparam int QUEUE_DEPTH = 2;

    // Item operations
    localparam logic OP_REFRESH = 1'b0;
    localparam logic OP_SET     = 1'b1;

    // Display modes
    localparam logic [1:0] MODE_CHANNEL  = 2'd0;
    localparam logic [1:0] MODE_FUNCTION = 2'd1;
    localparam logic [1:0] MODE_COUNT    = 2'd2;
    localparam logic [1:0] MODE_KEEP     = 2'd3;

    // Work functions
    localparam logic [1:0] WF_OTHER    = 2'd0;
    localparam logic [1:0] WF_RECEIVE  = 2'd1;
    localparam logic [1:0] WF_TRANSMIT = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_DISPLAY_ENABLE = 2'd0;
    localparam logic [1:0] REG_CARRIER_TEST   = 2'd1;
    localparam logic [1:0] REG_WORK_FUNCTION  = 2'd2;
    localparam logic [1:0] REG_SINGLE_TX      = 2'd3;

    // Command kinds passed from front to back
    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_OFF  = 2'd1;
    localparam logic [1:0] KIND_SET  = 2'd2;

    // Formatting actions for a set command
    localparam logic [2:0] FMT_CARRIER = 3'd0;
    localparam logic [2:0] FMT_CHANNEL = 3'd1;
    localparam logic [2:0] FMT_FUNC_RX = 3'd2;
    localparam logic [2:0] FMT_FUNC_TX = 3'd3;
    localparam logic [2:0] FMT_COUNT   = 3'd4;
    localparam logic [2:0] FMT_COUNT_A = 3'd5;

    // Glyph indices
    localparam logic [4:0] G_EIGHT = 5'd8;
    localparam logic [4:0] G_BLANK = 5'd11;
    localparam logic [4:0] G_CDOT  = 5'd14;
    localparam logic [4:0] G_F     = 5'd16;
    localparam logic [4:0] G_A     = 5'd17;
    localparam logic [4:0] G_B     = 5'd18;
    localparam logic [4:0] G_C     = 5'd19;
    localparam logic [4:0] G_H     = 5'd20;

    typedef struct packed {
        logic [1:0]         kind;
        logic [2:0]         fmt;
        logic [VALUE_W-1:0] value;
    } cmd_t;

    // Active-low segment byte for a glyph; indices past the table are blank
    function automatic logic [7:0] glyph_bits(input logic [GLYPH_W-1:0] g);
        logic [7:0] bits;
        case (g)
            5'd0:    bits = 8'hC0;
            5'd1:    bits = 8'hF9;
            5'd2:    bits = 8'hA4;
            5'd3:    bits = 8'hB0;
            5'd4:    bits = 8'h99;
            5'd5:    bits = 8'h92;
            5'd6:    bits = 8'h82;
            5'd7:    bits = 8'hF8;
            5'd8:    bits = 8'h80;
            5'd9:    bits = 8'h90;
            5'd10:   bits = 8'hBF;
            5'd11:   bits = 8'hFF;
            5'd12:   bits = 8'h86;
            5'd13:   bits = 8'h88;
            5'd14:   bits = 8'h46;
            5'd15:   bits = 8'h00;
            5'd16:   bits = 8'h8E;
            5'd17:   bits = 8'h88;
            5'd18:   bits = 8'h83;
            5'd19:   bits = 8'hC6;
            5'd20:   bits = 8'h0B;
            default: bits = 8'hFF;
        endcase
        return bits;
    endfunction

endpackage
`default_nettype wire

[src/sssf_if.sv]
`default_nettype none
interface sssf_item_if;
    logic                            valid;
    logic                            ready;
    logic                            operation;
    logic [sssf_pkg::VALUE_W-1:0]    value;
    logic [sssf_pkg::MODE_W-1:0]     display_mode;

    modport source (output valid, operation, value, display_mode, input ready);
    modport sink   (input valid, operation, value, display_mode, output ready);
endinterface

interface sssf_result_if;
    logic       valid;
    logic       ready;
    logic       serial_data;
    logic       latch;
    logic [3:0] digit_enable;
    logic       last;

    modport source (output valid, serial_data, latch, digit_enable, last, input ready);
    modport sink   (input valid, serial_data, latch, digit_enable, last, output ready);
endinterface

interface sssf_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [sssf_pkg::CFG_INDEX_W-1:0]    index;
    logic [sssf_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[src/sssf_front.sv]
`default_nettype none
module sssf_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    sssf_item_if.sink          item,
    sssf_cfg_if.sink           cfg,
    input  wire logic          q_ready,
    output logic               push,
    output sssf_pkg::cmd_t     push_cmd
);

    logic       display_enable_reg;
    logic       carrier_test_reg;
    logic [1:0] work_function_reg;
    logic       single_tx_reg;

    logic       keep;
    logic       wf_active;

    assign cfg.ready  = 1'b1;
    assign item.ready = q_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            display_enable_reg <= 1'b1;
            carrier_test_reg   <= 1'b0;
            work_function_reg  <= sssf_pkg::WF_OTHER;
            single_tx_reg      <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                sssf_pkg::REG_DISPLAY_ENABLE: display_enable_reg <= cfg.data[0];
                sssf_pkg::REG_CARRIER_TEST:   carrier_test_reg   <= cfg.data[0];
                sssf_pkg::REG_WORK_FUNCTION:  work_function_reg  <= cfg.data;
                sssf_pkg::REG_SINGLE_TX:      single_tx_reg      <= cfg.data[0];
                default:                      ;
            endcase
        end
    end

    assign wf_active = (work_function_reg == sssf_pkg::WF_RECEIVE) ||
                       (work_function_reg == sssf_pkg::WF_TRANSMIT);

    // Classify: resolve the formatting action now, drop sets that change nothing
    always_comb
    begin
        keep           = 1'b1;
        push_cmd.value = item.value;
        push_cmd.fmt   = sssf_pkg::FMT_CARRIER;
        push_cmd.kind  = sssf_pkg::KIND_SET;
        if (item.operation == sssf_pkg::OP_REFRESH)
        begin
            push_cmd.kind = display_enable_reg ? sssf_pkg::KIND_TICK : sssf_pkg::KIND_OFF;
        end
        else if (carrier_test_reg)
        begin
            push_cmd.fmt = sssf_pkg::FMT_CARRIER;
        end
        else if (!wf_active)
        begin
            keep = 1'b0;
        end
        else
        begin
            case (item.display_mode)
                sssf_pkg::MODE_CHANNEL:
                    push_cmd.fmt = sssf_pkg::FMT_CHANNEL;
                sssf_pkg::MODE_FUNCTION:
                    push_cmd.fmt = (work_function_reg == sssf_pkg::WF_RECEIVE) ?
                                   sssf_pkg::FMT_FUNC_RX : sssf_pkg::FMT_FUNC_TX;
                sssf_pkg::MODE_COUNT:
                    push_cmd.fmt = ((work_function_reg == sssf_pkg::WF_TRANSMIT) &&
                                    single_tx_reg) ?
                                   sssf_pkg::FMT_COUNT_A : sssf_pkg::FMT_COUNT;
                default:
                    keep = 1'b0;
            endcase
        end
    end

    assign push = item.valid && q_ready && keep;

endmodule
`default_nettype wire

[src/sssf_queue.sv]
`default_nettype none
module sssf_queue #(
    parameter int DEPTH = sssf_pkg::QUEUE_DEPTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire sssf_pkg::cmd_t push_cmd,
    output logic                ready,
    input  wire logic           pop,
    output logic                q_valid,
    output sssf_pkg::cmd_t      q_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sssf_pkg::cmd_t   slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign ready   = (count_reg != CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_cmd   = slot_reg[rd_ptr_reg];
    assign do_push = push && ready;
    assign do_pop  = pop && q_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

[src/sssf_back.sv]
`default_nettype none
`include "assert_macros.svh"
module sssf_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    input  wire sssf_pkg::cmd_t q_cmd,
    output logic               pop,
    sssf_result_if.source      result
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SHIFT = 3'd1;
    localparam logic [2:0] ST_OFF   = 3'd2;
    localparam logic [2:0] ST_DIGIT = 3'd3;
    localparam logic [2:0] ST_APPLY = 3'd4;

    localparam int GW = sssf_pkg::GLYPH_W;
    localparam int SW = sssf_pkg::SCAN_W;
    localparam int VW = sssf_pkg::VALUE_W;

    logic [2:0]     state_reg,  state_next;
    sssf_pkg::cmd_t cmd_reg,    cmd_next;
    logic [2:0]     cnt_reg,    cnt_next;
    logic [7:0]     shift_reg,  shift_next;
    logic [SW-1:0]  pos_reg,    pos_next;
    logic [SW-1:0]  scan_reg,   scan_next;
    logic [VW-1:0]  rem_reg,    rem_next;
    logic [GW-1:0]  glyph_reg  [sssf_pkg::DIGIT_COUNT];
    logic [GW-1:0]  glyph_next [sssf_pkg::DIGIT_COUNT];
    logic [3:0]     digit_reg  [sssf_pkg::DIGIT_COUNT];
    logic [3:0]     digit_next [sssf_pkg::DIGIT_COUNT];

    logic           out_valid_reg,  out_valid_next;
    logic           serial_reg,     serial_next;
    logic           latch_reg,      latch_next;
    logic [3:0]     enable_reg,     enable_next;
    logic           last_reg,       last_next;

    logic           slot_free;
    logic           take;
    logic [32:0]    product;
    logic [12:0]    quot;
    logic [VW:0]    times_ten;
    logic [VW-1:0]  diff;

    assign result.valid        = out_valid_reg;
    assign result.serial_data  = serial_reg;
    assign result.latch        = latch_reg;
    assign result.digit_enable = enable_reg;
    assign result.last         = last_reg;

    assign slot_free = !out_valid_reg || result.ready;

    // Divide by ten through the reciprocal; exact for any 16-bit remainder
    assign product   = rem_reg * 17'd52429;
    assign quot      = product[31:19];
    assign times_ten = {1'b0, quot, 3'b000} + {3'b000, quot, 1'b0};
    assign diff      = rem_reg - times_ten[VW-1:0];

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        cnt_next       = cnt_reg;
        shift_next     = shift_reg;
        pos_next       = pos_reg;
        scan_next      = scan_reg;
        rem_next       = rem_reg;
        glyph_next     = glyph_reg;
        digit_next     = digit_reg;
        out_valid_next = out_valid_reg && !result.ready;
        serial_next    = serial_reg;
        latch_next     = latch_reg;
        enable_next    = enable_reg;
        last_next      = last_reg;
        take           = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                take = q_valid;
            end
            ST_SHIFT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    serial_next    = shift_reg[7];
                    latch_next     = (cnt_reg == 3'd7);
                    last_next      = (cnt_reg == 3'd7);
                    enable_next    = (cnt_reg == 3'd7) ? (4'b0001 << pos_reg) : 4'b0000;
                    shift_next     = {shift_reg[6:0], 1'b0};
                    cnt_next       = cnt_reg + 3'd1;
                    if (cnt_reg == 3'd7)
                    begin
                        state_next = ST_IDLE;
                        take       = q_valid;
                    end
                end
            end
            ST_OFF:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    serial_next    = 1'b0;
                    latch_next     = 1'b0;
                    enable_next    = 4'b0000;
                    last_next      = 1'b1;
                    scan_next      = '0;
                    state_next     = ST_IDLE;
                    take           = q_valid;
                end
            end
            ST_DIGIT:
            begin
                digit_next[cnt_reg[1:0]] = diff[3:0];
                rem_next                 = {3'b000, quot};
                cnt_next                 = cnt_reg + 3'd1;
                if (cnt_reg == 3'd3)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                case (cmd_reg.fmt)
                    sssf_pkg::FMT_CARRIER:
                    begin
                        glyph_next[3] = sssf_pkg::G_C;
                        glyph_next[2] = sssf_pkg::G_H;
                        glyph_next[1] = {1'b0, digit_reg[1]};
                        glyph_next[0] = {1'b0, digit_reg[0]};
                    end
                    sssf_pkg::FMT_CHANNEL:
                    begin
                        glyph_next[3] = sssf_pkg::G_F;
                        glyph_next[2] = sssf_pkg::G_C;
                        glyph_next[1] = {1'b0, digit_reg[1]};
                        glyph_next[0] = {1'b0, digit_reg[0]};
                    end
                    sssf_pkg::FMT_FUNC_RX:
                    begin
                        glyph_next[3] = sssf_pkg::G_F;
                        glyph_next[2] = sssf_pkg::G_CDOT;
                        glyph_next[1] = sssf_pkg::G_BLANK;
                        glyph_next[0] = {1'b0, digit_reg[0]};
                    end
                    sssf_pkg::FMT_FUNC_TX:
                    begin
                        glyph_next[3] = sssf_pkg::G_F;
                        glyph_next[2] = sssf_pkg::G_CDOT;
                        glyph_next[1] = sssf_pkg::G_BLANK;
                        // hold units unless the value names a letter
                        if (cmd_reg.value == 16'd1)
                        begin
                            glyph_next[0] = sssf_pkg::G_A;
                        end
                        else if (cmd_reg.value == 16'd2)
                        begin
                            glyph_next[0] = sssf_pkg::G_B;
                        end
                        else if (cmd_reg.value == 16'd3)
                        begin
                            glyph_next[0] = sssf_pkg::G_C;
                        end
                    end
                    sssf_pkg::FMT_COUNT:
                    begin
                        glyph_next[3] = {1'b0, digit_reg[3]};
                        glyph_next[2] = {1'b0, digit_reg[2]};
                        glyph_next[1] = {1'b0, digit_reg[1]};
                        glyph_next[0] = {1'b0, digit_reg[0]};
                    end
                    sssf_pkg::FMT_COUNT_A:
                    begin
                        glyph_next[3] = sssf_pkg::G_A;
                        glyph_next[2] = {1'b0, digit_reg[2]};
                        glyph_next[1] = {1'b0, digit_reg[1]};
                        glyph_next[0] = {1'b0, digit_reg[0]};
                    end
                    default:
                    begin
                    end
                endcase
                state_next = ST_IDLE;
                take       = q_valid;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Load the next transaction; glyph and scan reads see this cycle's updates
        if (take)
        begin
            cmd_next = q_cmd;
            cnt_next = 3'd0;
            case (q_cmd.kind)
                sssf_pkg::KIND_TICK:
                begin
                    shift_next = sssf_pkg::glyph_bits(glyph_next[scan_next]);
                    pos_next   = scan_next;
                    scan_next  = scan_next + 1'b1;
                    state_next = ST_SHIFT;
                end
                sssf_pkg::KIND_OFF:
                begin
                    state_next = ST_OFF;
                end
                default:
                begin
                    rem_next   = q_cmd.value;
                    state_next = ST_DIGIT;
                end
            endcase
        end
    end

    assign pop = take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            scan_reg      <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < sssf_pkg::DIGIT_COUNT; i++)
            begin
                glyph_reg[i] <= sssf_pkg::G_EIGHT;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            scan_reg      <= scan_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            glyph_reg     <= glyph_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        shift_reg  <= shift_next;
        rem_reg    <= rem_next;
        digit_reg  <= digit_next;
        serial_reg <= serial_next;
        latch_reg  <= latch_next;
        enable_reg <= enable_next;
        last_reg   <= last_next;
    end

    `ASSERT_IMPLIES(a_enable_onehot, clk, rst_n, out_valid_reg, $onehot0(enable_reg))
    `ASSERT_IMPLIES(a_enable_on_last, clk, rst_n, out_valid_reg && (|enable_reg), latch_reg && last_reg)
    `ASSERT_IMPLIES(a_scan_ahead, clk, rst_n, state_reg == ST_SHIFT, scan_reg == pos_reg + 2'd1)

endmodule
`default_nettype wire

[src/seven_segment_scan_formatter_top.sv]
// Refresh tick: the item passes the queue, the back end loads the shift register, then eight
// results follow, one per cycle while the result sink is ready; a new tick is taken only as
// the serial shift of the current one ends. Disabled tick: one result, one tick per cycle while
// results are accepted. Set value: four divide-by-ten steps and a glyph write in the back end, no result.
// Reset: config registers to defaults, all digits show glyph eight, scan at digit 0, queue empty.
`default_nettype none
module seven_segment_scan_formatter_top #(
    parameter int QUEUE_DEPTH = sssf_pkg::QUEUE_DEPTH
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    sssf_item_if.sink       item,
    sssf_result_if.source   result,
    sssf_cfg_if.sink        cfg
);

    logic           push;
    sssf_pkg::cmd_t push_cmd;
    logic           q_ready;
    logic           q_valid;
    sssf_pkg::cmd_t q_cmd;
    logic           pop;

    sssf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .cfg      (cfg),
        .q_ready  (q_ready),
        .push     (push),
        .push_cmd (push_cmd)
    );

    sssf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .ready    (q_ready),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    sssf_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .pop     (pop),
        .result  (result)
    );

endmodule
`default_nettype wire

[dv/seven_segment_scan_formatter_top_tb.sv]
`timescale 1ns / 1ps

typedef struct packed {
    logic       serial_data;
    logic       latch;
    logic [3:0] digit_enable;
    logic       last;
} seg_beat_t;

class scan_scoreboard;
    localparam int GW = sssf_pkg::GLYPH_W;
    localparam int VW = sssf_pkg::VALUE_W;
    localparam int MW = sssf_pkg::MODE_W;
    localparam int IW = sssf_pkg::CFG_INDEX_W;
    localparam int DW = sssf_pkg::CFG_DATA_W;

    logic                        display_en;
    logic                        carrier_test;
    logic [1:0]                  work_fn;
    logic                        single_tx;
    logic [GW-1:0]               glyphs [sssf_pkg::DIGIT_COUNT];
    logic [sssf_pkg::SCAN_W-1:0] scan_pos;
    seg_beat_t                   pending_beats [$];
    int                          errors;

    function new();
        display_en   = 1'b1;
        carrier_test = 1'b0;
        work_fn      = sssf_pkg::WF_OTHER;
        single_tx    = 1'b0;
        foreach (glyphs[i])
            glyphs[i] = sssf_pkg::G_EIGHT;
        scan_pos = '0;
        errors   = 0;
    endfunction

    function void write_reg(logic [IW-1:0] idx, logic [DW-1:0] data);
        case (idx)
            sssf_pkg::REG_DISPLAY_ENABLE: display_en   = data[0];
            sssf_pkg::REG_CARRIER_TEST:   carrier_test = data[0];
            sssf_pkg::REG_WORK_FUNCTION:  work_fn      = data;
            sssf_pkg::REG_SINGLE_TX:      single_tx    = data[0];
            default: ;
        endcase
    endfunction

    // Active-low segment byte; glyphs past the table are blank
    function logic [7:0] segment_code(logic [GW-1:0] g);
        logic [7:0] code;
        case (g)
            5'd0:    code = 8'hC0;
            5'd1:    code = 8'hF9;
            5'd2:    code = 8'hA4;
            5'd3:    code = 8'hB0;
            5'd4:    code = 8'h99;
            5'd5:    code = 8'h92;
            5'd6:    code = 8'h82;
            5'd7:    code = 8'hF8;
            5'd8:    code = 8'h80;
            5'd9:    code = 8'h90;
            5'd10:   code = 8'hBF;
            5'd11:   code = 8'hFF;
            5'd12:   code = 8'h86;
            5'd13:   code = 8'h88;
            5'd14:   code = 8'h46;
            5'd15:   code = 8'h00;
            5'd16:   code = 8'h8E;
            5'd17:   code = 8'h88;
            5'd18:   code = 8'h83;
            5'd19:   code = 8'hC6;
            5'd20:   code = 8'h0B;
            default: code = 8'hFF;
        endcase
        return code;
    endfunction

    function void format_digits(logic [VW-1:0] v, logic [MW-1:0] mode);
        int unsigned   n;
        logic [GW-1:0] units;
        logic [GW-1:0] tens;
        logic [GW-1:0] hund;
        logic [GW-1:0] thou;
        n     = v;
        units = GW'(n % 10);
        tens  = GW'(n % 100 / 10);
        hund  = GW'(n % 1000 / 100);
        thou  = GW'(n % 10000 / 1000);
        if (carrier_test)
        begin
            glyphs[3] = sssf_pkg::G_C;
            glyphs[2] = sssf_pkg::G_H;
            glyphs[1] = tens;
            glyphs[0] = units;
            return;
        end
        if (work_fn != sssf_pkg::WF_RECEIVE && work_fn != sssf_pkg::WF_TRANSMIT)
            return;
        case (mode)
            sssf_pkg::MODE_CHANNEL:
            begin
                glyphs[3] = sssf_pkg::G_F;
                glyphs[2] = sssf_pkg::G_C;
                glyphs[1] = tens;
                glyphs[0] = units;
            end
            sssf_pkg::MODE_FUNCTION:
            begin
                glyphs[3] = sssf_pkg::G_F;
                glyphs[2] = sssf_pkg::G_CDOT;
                glyphs[1] = sssf_pkg::G_BLANK;
                // transmit shows A/b/C for 1..3 and keeps the digit otherwise
                if (work_fn == sssf_pkg::WF_RECEIVE)
                    glyphs[0] = units;
                else if (n == 1)
                    glyphs[0] = sssf_pkg::G_A;
                else if (n == 2)
                    glyphs[0] = sssf_pkg::G_B;
                else if (n == 3)
                    glyphs[0] = sssf_pkg::G_C;
            end
            sssf_pkg::MODE_COUNT:
            begin
                glyphs[3] = (work_fn == sssf_pkg::WF_TRANSMIT && single_tx) ?
                            sssf_pkg::G_A : thou;
                glyphs[2] = hund;
                glyphs[1] = tens;
                glyphs[0] = units;
            end
            default: ;
        endcase
    endfunction

    function void note_item(logic op, logic [VW-1:0] v, logic [MW-1:0] mode);
        logic [7:0] code;
        seg_beat_t  beat;
        if (op == sssf_pkg::OP_SET)
        begin
            format_digits(v, mode);
            return;
        end
        if (!display_en)
        begin
            scan_pos = '0;
            beat = '0;
            beat.last = 1'b1;
            pending_beats.push_back(beat);
            return;
        end
        code = segment_code(glyphs[scan_pos]);
        for (int k = 0; k < 8; k++)
        begin
            beat.serial_data  = code[7 - k];
            beat.latch        = (k == 7);
            beat.digit_enable = (k == 7) ? (4'b0001 << scan_pos) : 4'b0000;
            beat.last         = (k == 7);
            pending_beats.push_back(beat);
        end
        scan_pos = scan_pos + 1'b1;
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    function void check_beat(seg_beat_t got);
        seg_beat_t want;
        if (pending_beats.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected result, expected none, actual %p", $time, got);
            return;
        end
        want = pending_beats.pop_front();
        compare_field("serial_data", want.serial_data, got.serial_data);
        compare_field("latch", want.latch, got.latch);
        compare_field("digit_enable", want.digit_enable, got.digit_enable);
        compare_field("last", want.last, got.last);
    endfunction

    function int outstanding();
        return pending_beats.size();
    endfunction
endclass

module seven_segment_scan_formatter_top_tb;
    localparam int VW = sssf_pkg::VALUE_W;
    localparam int MW = sssf_pkg::MODE_W;
    localparam int IW = sssf_pkg::CFG_INDEX_W;
    localparam int DW = sssf_pkg::CFG_DATA_W;

    logic           clk   = 1'b0;
    logic           rst_n = 1'b0;
    int unsigned    send_idle_pct = 18;
    int unsigned    recv_idle_pct = 82;
    scan_scoreboard board;

    sssf_item_if   item_ch ();
    sssf_result_if result_ch ();
    sssf_cfg_if    cfg_ch ();

    seven_segment_scan_formatter_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
        result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            board.check_beat({result_ch.serial_data, result_ch.latch,
                              result_ch.digit_enable, result_ch.last});
    end

    // Called at a falling edge; returns at the falling edge after the transaction,
    // leaving valid high so back-to-back items need no second assignment
    task automatic send_item(input logic op, input logic [VW-1:0] v,
                             input logic [MW-1:0] mode);
        if ($urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        item_ch.valid        <= 1'b1;
        item_ch.operation    <= op;
        item_ch.value        <= v;
        item_ch.display_mode <= mode;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        board.note_item(op, v, mode);
        @(negedge clk);
    endtask

    task automatic tick_run(input int count);
        for (int i = 0; i < count; i++)
            send_item(sssf_pkg::OP_REFRESH, VW'($urandom), MW'($urandom));
    endtask

    // Drop valid, drain outstanding results, then let queued set items finish
    task automatic settle();
        item_ch.valid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_regs(input logic [DW-1:0] de, input logic [DW-1:0] ct,
                              input logic [DW-1:0] wf, input logic [DW-1:0] st);
        logic [DW-1:0] vals [4];
        vals[sssf_pkg::REG_DISPLAY_ENABLE] = de;
        vals[sssf_pkg::REG_CARRIER_TEST]   = ct;
        vals[sssf_pkg::REG_WORK_FUNCTION]  = wf;
        vals[sssf_pkg::REG_SINGLE_TX]      = st;
        for (int i = 0; i < 4; i++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= IW'(i);
            cfg_ch.data  <= vals[i];
            @(posedge clk);
            while (!cfg_ch.ready)
                @(posedge clk);
            board.write_reg(IW'(i), vals[i]);
            @(negedge clk);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [VW-1:0] pick_value();
        case ($urandom_range(0, 4))
            0:       return VW'($urandom_range(0, 4));
            1:       return '1;
            default: return VW'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [DW-1:0] de;
        logic [DW-1:0] ct;
        logic [DW-1:0] wf;
        logic [DW-1:0] st;
        int            sent;

        item_ch.valid        = 1'b0;
        item_ch.operation    = sssf_pkg::OP_REFRESH;
        item_ch.value        = '0;
        item_ch.display_mode = sssf_pkg::MODE_KEEP;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = sssf_pkg::REG_DISPLAY_ENABLE;
        cfg_ch.data          = '0;
        board = new();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // After reset every digit shows eight; work function other leaves it so
        tick_run(4);
        send_item(sssf_pkg::OP_SET, 16'd1234, sssf_pkg::MODE_COUNT);
        tick_run(1);

        settle();
        write_regs(2'd1, 2'd0, sssf_pkg::WF_RECEIVE, 2'd0);
        send_item(sssf_pkg::OP_SET, 16'hFFFF, sssf_pkg::MODE_CHANNEL);
        tick_run(3);
        send_item(sssf_pkg::OP_SET, 16'd9, sssf_pkg::MODE_FUNCTION);
        tick_run(1);
        send_item(sssf_pkg::OP_SET, 16'd0, sssf_pkg::MODE_COUNT);
        send_item(sssf_pkg::OP_SET, 16'hFFFF, sssf_pkg::MODE_KEEP);
        tick_run(2);

        // Transmit: function letters, unchanged last digit, single-send count
        settle();
        write_regs(2'd1, 2'd0, sssf_pkg::WF_TRANSMIT, 2'd1);
        send_item(sssf_pkg::OP_SET, 16'd2, sssf_pkg::MODE_FUNCTION);
        send_item(sssf_pkg::OP_SET, 16'd7, sssf_pkg::MODE_FUNCTION);
        tick_run(2);
        send_item(sssf_pkg::OP_SET, 16'd9999, sssf_pkg::MODE_COUNT);
        tick_run(2);

        // Carrier test overrides mode and work function
        settle();
        write_regs(2'd1, 2'd1, 2'd3, 2'd1);
        send_item(sssf_pkg::OP_SET, 16'd12345, sssf_pkg::MODE_KEEP);
        tick_run(2);

        // Display off: single result per tick, scan back to digit 0
        settle();
        write_regs(2'd2, 2'd2, sssf_pkg::WF_TRANSMIT, 2'd2);
        tick_run(2);
        send_item(sssf_pkg::OP_SET, 16'd1, sssf_pkg::MODE_FUNCTION);
        send_item(sssf_pkg::OP_SET, 16'd3, sssf_pkg::MODE_FUNCTION);
        tick_run(1);

        for (int round = 0; round < 6; round++)
        begin
            settle();
            case (round / 2)
                0:
                begin
                    send_idle_pct = 18;
                    recv_idle_pct = 82;
                end
                1:
                begin
                    send_idle_pct = 82;
                    recv_idle_pct = 18;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            de = DW'($urandom);
            if ($urandom_range(0, 4) != 0)
                de[0] = 1'b1;
            ct = DW'($urandom);
            if ($urandom_range(0, 3) != 0)
                ct[0] = 1'b0;
            wf = DW'($urandom);
            if ($urandom_range(0, 3) != 0)
                wf = ($urandom_range(0, 1) != 0) ? sssf_pkg::WF_RECEIVE :
                                                   sssf_pkg::WF_TRANSMIT;
            st = DW'($urandom);
            write_regs(de, ct, wf, st);

            sent = 0;
            while (sent < 13)
            begin
                if ($urandom_range(0, 2) != 0)
                begin
                    // Set a value, then scan all four digits
                    send_item(sssf_pkg::OP_SET, pick_value(), MW'($urandom));
                    tick_run(4);
                    sent += 5;
                end
                else
                begin
                    send_item(1'($urandom), pick_value(), MW'($urandom));
                    sent++;
                end
            end
        end

        settle();
        if (board.errors == 0)
            $display("seven_segment_scan_formatter_top_tb: done, clean");
        else
            $display("seven_segment_scan_formatter_top_tb: done, errors");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("seven_segment_scan_formatter_top_tb: done, errors");
        $finish;
    end
endmodule

[filelist.f]
+incdir+src
src/sssf_pkg.sv
src/sssf_if.sv
src/sssf_front.sv
src/sssf_queue.sv
src/sssf_back.sv
src/seven_segment_scan_formatter_top.sv
dv/seven_segment_scan_formatter_top_tb.sv
